// ----- rtl/csvs_pkg.sv -----
// Shared types, constants and helpers for the CSV line field splitter.
package csvs_pkg;

    localparam int UNIT_W          = 16;
    localparam int KIND_W          = 2;
    localparam int SPACE_DEPTH_DEF = 16;

    localparam logic [UNIT_W-1:0] CH_COMMA = 16'h002C;
    localparam logic [UNIT_W-1:0] CH_QUOTE = 16'h0022;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_DRAIN = 2'd1,
        ST_LAST  = 2'd2
    } t_state;

    typedef enum logic [1:0] {
        MODE_NORMAL     = 2'd0,
        MODE_QUOTED     = 2'd1,
        MODE_QUOTE_SEEN = 2'd2
    } t_mode;

    typedef enum logic [KIND_W-1:0] {
        KIND_CHAR      = 2'd0,
        KIND_FIELD_END = 2'd1,
        KIND_LINE_END  = 2'd2
    } t_kind;

    function automatic logic is_space(input logic [UNIT_W-1:0] c);
        return c inside {[16'h0009:16'h000D], 16'h0020, 16'h0085, 16'h00A0, 16'h1680,
                         [16'h2000:16'h200A], 16'h2028, 16'h2029, 16'h202F,
                         16'h205F, 16'h3000};
    endfunction

endpackage

// ----- rtl/csvs_if.sv -----
// Beat channels of the CSV line field splitter: input units and result items.
interface csvs_in_if;
    logic                        valid;
    logic                        ready;
    logic [csvs_pkg::UNIT_W-1:0] code_unit;
    logic                        end_of_line;

    modport source (output valid, code_unit, end_of_line, input ready);
    modport sink   (input valid, code_unit, end_of_line, output ready);
endinterface

interface csvs_out_if;
    logic                        valid;
    logic                        ready;
    logic [csvs_pkg::UNIT_W-1:0] out_unit;
    logic [csvs_pkg::KIND_W-1:0] kind;
    logic                        trim_overflow;
    logic                        last_of_run;

    modport source (output valid, out_unit, kind, trim_overflow, last_of_run, input ready);
    modport sink   (input valid, out_unit, kind, trim_overflow, last_of_run, output ready);
endinterface

// ----- rtl/csv_line_field_splitter.sv -----
// Top level: quote/comma parser, trim sequencer and output register.
// A result sits in the output register in the cycle after its input beat.
// Throughput: one beat per cycle unless the output stalls; a non-space after
// buffered spaces holds input off (one buffer read per cycle, then the unit).
// Reset: i_rst_n synchronous, active low; clears the parser and output valid.
// The space buffer is not cleared; entries are read only below the fill count.
module csv_line_field_splitter #(
    parameter int SPACE_DEPTH = csvs_pkg::SPACE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    csvs_in_if.sink         i_in,
    csvs_out_if.source      o_out
);
    import csvs_pkg::*;

    localparam int AW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;
    localparam int CW = $clog2(SPACE_DEPTH + 1);

    t_state            r_state, n_state;
    t_mode             r_mode, n_mode;
    logic              r_started, n_started;
    logic [CW-1:0]     r_count, n_count;
    logic              r_ovf_seen, n_ovf_seen;
    logic [CW-1:0]     r_idx, n_idx;
    logic [UNIT_W-1:0] r_pend, n_pend;

    logic              r_ov, n_ov;
    logic [UNIT_W-1:0] r_unit, n_unit;
    t_kind             r_kind, n_kind;
    logic              r_oflag, n_oflag;
    logic              r_last, n_last;

    logic              out_free;
    logic              in_ready;
    logic              in_fire;
    logic [UNIT_W-1:0] c;
    t_mode             eff_mode;
    logic              do_add;
    logic              do_end;
    t_kind             end_kind;
    logic [UNIT_W-1:0] add_ch;
    logic              emit;
    logic [UNIT_W-1:0] e_unit;
    t_kind             e_kind;
    logic              e_ovf;
    logic              e_last;
    logic [CW-1:0]     idx_inc;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [UNIT_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [UNIT_W-1:0] ram_rdata;

    csvs_space_ram #(
        .DEPTH (SPACE_DEPTH),
        .AW    (AW)
    ) u_space_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_ov || o_out.ready;
    assign in_ready = (r_state == ST_IDLE) && out_free;
    assign in_fire  = i_in.valid && in_ready;
    assign c        = i_in.code_unit;
    assign idx_inc  = CW'(r_idx + 1'b1);

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_started  = r_started;
        n_count    = r_count;
        n_ovf_seen = r_ovf_seen;
        n_idx      = r_idx;
        n_pend     = r_pend;
        ram_we     = 1'b0;
        ram_waddr  = r_count[AW-1:0];
        ram_wdata  = c;
        ram_raddr  = r_idx[AW-1:0];
        eff_mode   = r_mode;
        do_add     = 1'b0;
        do_end     = 1'b0;
        end_kind   = KIND_FIELD_END;
        add_ch     = c;
        emit       = 1'b0;
        e_unit     = '0;
        e_kind     = KIND_CHAR;
        e_ovf      = 1'b0;
        e_last     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                ram_raddr = '0;
                if (in_fire) begin
                    if ((r_mode == MODE_QUOTE_SEEN) && (c != CH_QUOTE)) begin
                        eff_mode = MODE_NORMAL;
                    end
                    if (i_in.end_of_line) begin
                        do_end   = 1'b1;
                        end_kind = KIND_LINE_END;
                        n_mode   = MODE_NORMAL;
                    end else begin
                        case (eff_mode)
                            MODE_QUOTE_SEEN: begin
                                do_add = 1'b1;
                                add_ch = CH_QUOTE;
                                n_mode = MODE_QUOTED;
                            end
                            MODE_QUOTED: begin
                                if (c == CH_QUOTE) begin
                                    n_mode = MODE_QUOTE_SEEN;
                                end else begin
                                    do_add = 1'b1;
                                end
                            end
                            default: begin
                                n_mode = MODE_NORMAL;
                                if (c == CH_COMMA) begin
                                    do_end = 1'b1;
                                end else if (c == CH_QUOTE) begin
                                    n_mode = MODE_QUOTED;
                                end else begin
                                    do_add = 1'b1;
                                end
                            end
                        endcase
                    end

                    if (do_end) begin
                        emit       = 1'b1;
                        e_kind     = end_kind;
                        e_ovf      = r_ovf_seen;
                        e_last     = 1'b1;
                        n_started  = 1'b0;
                        n_count    = '0;
                        n_ovf_seen = 1'b0;
                    end else if (do_add) begin
                        if (!r_started) begin
                            if (!is_space(add_ch)) begin
                                n_started = 1'b1;
                                emit      = 1'b1;
                                e_unit    = add_ch;
                                e_last    = 1'b1;
                            end
                        end else if (is_space(add_ch)) begin
                            if (r_count < CW'(SPACE_DEPTH)) begin
                                ram_we    = 1'b1;
                                ram_wdata = add_ch;
                                n_count   = CW'(r_count + 1'b1);
                            end else begin
                                n_ovf_seen = 1'b1;
                            end
                        end else if (r_count == '0) begin
                            emit   = 1'b1;
                            e_unit = add_ch;
                            e_last = 1'b1;
                        end else begin
                            n_pend  = add_ch;
                            n_idx   = '0;
                            n_state = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    emit      = 1'b1;
                    e_unit    = ram_rdata;
                    n_idx     = idx_inc;
                    ram_raddr = idx_inc[AW-1:0];
                    if (idx_inc == r_count) begin
                        n_state = ST_LAST;
                    end
                end
            end
            ST_LAST: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_unit  = r_pend;
                    e_last  = 1'b1;
                    n_count = '0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        n_ov    = r_ov;
        n_unit  = r_unit;
        n_kind  = r_kind;
        n_oflag = r_oflag;
        n_last  = r_last;
        if (out_free) begin
            n_ov = emit;
        end
        if (emit) begin
            n_unit  = e_unit;
            n_kind  = e_kind;
            n_oflag = e_ovf;
            n_last  = e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_mode     <= MODE_NORMAL;
            r_started  <= 1'b0;
            r_count    <= '0;
            r_ovf_seen <= 1'b0;
            r_idx      <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_mode     <= n_mode;
            r_started  <= n_started;
            r_count    <= n_count;
            r_ovf_seen <= n_ovf_seen;
            r_idx      <= n_idx;
            r_ov       <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend  <= n_pend;
        r_unit  <= n_unit;
        r_kind  <= n_kind;
        r_oflag <= n_oflag;
        r_last  <= n_last;
    end

    assign i_in.ready          = in_ready;
    assign o_out.valid         = r_ov;
    assign o_out.out_unit      = r_unit;
    assign o_out.kind          = r_kind;
    assign o_out.trim_overflow = r_oflag;
    assign o_out.last_of_run   = r_last;

endmodule

// ----- rtl/csvs_space_ram.sv -----
// Trailing whitespace buffer: one write port, one registered read port.
module csvs_space_ram #(
    parameter int DEPTH = csvs_pkg::SPACE_DEPTH_DEF,
    parameter int AW    = 4
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [csvs_pkg::UNIT_W-1:0] i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [csvs_pkg::UNIT_W-1:0] o_rdata
);
    import csvs_pkg::*;

    logic [UNIT_W-1:0] mem [DEPTH];
    logic [UNIT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
